[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ERP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ERP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/erp_pkg.sv]
// Types, constants and sine table for the point rotate/translate block.
package erp_pkg;

  localparam int COORD_BITS    = 24;
  localparam int FRAC_BITS     = 14;
  localparam int ANGLE_BITS    = 8;
  localparam int TRIG_BITS     = 16;
  localparam int QM_BITS       = 17;
  localparam int M_BITS        = 18;
  localparam int PROD_BITS     = COORD_BITS + M_BITS;
  localparam int ACC_BITS      = PROD_BITS + 2;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int SETTLE_BITS   = 3;
  localparam int POINT_BITS    = 3 * COORD_BITS;

  localparam logic [SETTLE_BITS-1:0] SETTLE_CYCLES = 3'd4;

  localparam logic [2:0] REG_ANGLE_X = 3'd0;
  localparam logic [2:0] REG_ANGLE_Y = 3'd1;
  localparam logic [2:0] REG_ANGLE_Z = 3'd2;
  localparam logic [2:0] REG_SHIFT_X = 3'd3;
  localparam logic [2:0] REG_SHIFT_Y = 3'd4;
  localparam logic [2:0] REG_SHIFT_Z = 3'd5;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 8'd64;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TRIG_BITS-1:0]  trig_t;
  typedef logic signed [QM_BITS-1:0]    qm_t;
  typedef logic signed [M_BITS-1:0]     mentry_t;

  typedef struct packed {
    mentry_t [2:0][2:0] m;
    coord_t  [2:0]      shift;
  } xform_t;

  typedef struct packed {
    coord_t [2:0] p;
    logic         last;
  } point_t;

  function automatic logic [14:0] quarter_sin(input logic [6:0] idx);
    logic [14:0] v;
    case (idx)
      7'd0:  v = 15'd0;     7'd1:  v = 15'd402;   7'd2:  v = 15'd804;
      7'd3:  v = 15'd1205;  7'd4:  v = 15'd1606;  7'd5:  v = 15'd2006;
      7'd6:  v = 15'd2404;  7'd7:  v = 15'd2801;  7'd8:  v = 15'd3196;
      7'd9:  v = 15'd3590;  7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
      7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
      7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
      7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
      7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
      7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
      7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
      7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
      7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
      7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
      7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
      7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
      7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
      7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
      7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
      7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
      7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
      7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
      7'd63: v = 15'd16379; 7'd64: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  function automatic trig_t rom_sin(input logic [ANGLE_BITS-1:0] k);
    logic [6:0] idx;
    trig_t      mag;
    idx = k[6] ? (7'd64 - {1'b0, k[5:0]}) : {1'b0, k[5:0]};
    mag = trig_t'({1'b0, quarter_sin(idx)});
    return k[7] ? -mag : mag;
  endfunction

  function automatic qm_t qmul(input qm_t a, input qm_t b);
    logic signed [2*QM_BITS-1:0] pr;
    pr = a * b;
    pr = pr + (2*QM_BITS)'(1 << (FRAC_BITS - 1));
    return pr[FRAC_BITS +: QM_BITS];
  endfunction

endpackage

[rtl/erp_queue.sv]
// Two-entry point queue between the front and back parts.
module erp_queue
  import erp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  point_t push_data,
  output logic   full,
  output logic   pop_valid,
  output point_t pop_data,
  input  logic   pop
);

  point_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/erp_front.sv]
// Front part: register port, rotation matrix pipeline and point intake.
module erp_front
  import erp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [POINT_BITS-1:0]    in_tdata,
  input  logic                     in_tlast,
  input  logic                     queue_full,
  output logic                     push,
  output point_t                   push_data,
  output xform_t                   xform
);

  logic [ANGLE_BITS-1:0]  angle_r [3];
  coord_t                 shift_r [3];
  logic [SETTLE_BITS-1:0] settle_r, settle_nxt;
  logic                   cfg_wr;
  logic [2:0]             cfg_idx;

  trig_t   sx_r, cx_r, sy_r, cy_r, sz_r, cz_r;
  qm_t     sxsy_r, cxsy_r, m00_r, m01_r, m02_r, m12_r, m22_r;
  qm_t     sx2_r, cx2_r, sz2_r, cz2_r;
  qm_t     t10a_r, t10b_r, t11a_r, t11b_r, t20a_r, t20b_r, t21a_r, t21b_r;
  qm_t     m00b_r, m01b_r, m02b_r, m12b_r, m22b_r;
  mentry_t m_r [3][3];

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_ANGLE_X: cfg_prdata = {{(CFG_DATA_BITS-ANGLE_BITS){1'b0}}, angle_r[0]};
      REG_ANGLE_Y: cfg_prdata = {{(CFG_DATA_BITS-ANGLE_BITS){1'b0}}, angle_r[1]};
      REG_ANGLE_Z: cfg_prdata = {{(CFG_DATA_BITS-ANGLE_BITS){1'b0}}, angle_r[2]};
      REG_SHIFT_X: cfg_prdata = {{(CFG_DATA_BITS-COORD_BITS){1'b0}}, shift_r[0]};
      REG_SHIFT_Y: cfg_prdata = {{(CFG_DATA_BITS-COORD_BITS){1'b0}}, shift_r[1]};
      REG_SHIFT_Z: cfg_prdata = {{(CFG_DATA_BITS-COORD_BITS){1'b0}}, shift_r[2]};
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        angle_r[i] <= '0;
        shift_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ANGLE_X: angle_r[0] <= cfg_pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_Y: angle_r[1] <= cfg_pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_Z: angle_r[2] <= cfg_pwdata[ANGLE_BITS-1:0];
        REG_SHIFT_X: shift_r[0] <= cfg_pwdata[COORD_BITS-1:0];
        REG_SHIFT_Y: shift_r[1] <= cfg_pwdata[COORD_BITS-1:0];
        REG_SHIFT_Z: shift_r[2] <= cfg_pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Hold intake until the matrix pipeline has settled on new angles.
  always_comb begin
    if (cfg_wr) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r <= rom_sin(angle_r[0]);
    cx_r <= rom_sin(angle_r[0] + QUARTER_TURN);
    sy_r <= rom_sin(angle_r[1]);
    cy_r <= rom_sin(angle_r[1] + QUARTER_TURN);
    sz_r <= rom_sin(angle_r[2]);
    cz_r <= rom_sin(angle_r[2] + QUARTER_TURN);

    sxsy_r <= qmul(qm_t'(sx_r), qm_t'(sy_r));
    cxsy_r <= qmul(qm_t'(cx_r), qm_t'(sy_r));
    m00_r  <= qmul(qm_t'(cy_r), qm_t'(cz_r));
    m01_r  <= qmul(qm_t'(cy_r), qm_t'(sz_r));
    m02_r  <= -qm_t'(sy_r);
    m12_r  <= qmul(qm_t'(sx_r), qm_t'(cy_r));
    m22_r  <= qmul(qm_t'(cx_r), qm_t'(cy_r));
    sx2_r  <= qm_t'(sx_r);
    cx2_r  <= qm_t'(cx_r);
    sz2_r  <= qm_t'(sz_r);
    cz2_r  <= qm_t'(cz_r);

    t10a_r <= qmul(sxsy_r, cz2_r);
    t10b_r <= qmul(cx2_r, sz2_r);
    t11a_r <= qmul(sxsy_r, sz2_r);
    t11b_r <= qmul(cx2_r, cz2_r);
    t20a_r <= qmul(cxsy_r, cz2_r);
    t20b_r <= qmul(sx2_r, sz2_r);
    t21a_r <= qmul(cxsy_r, sz2_r);
    t21b_r <= qmul(sx2_r, cz2_r);
    m00b_r <= m00_r;
    m01b_r <= m01_r;
    m02b_r <= m02_r;
    m12b_r <= m12_r;
    m22b_r <= m22_r;

    m_r[0][0] <= mentry_t'(m00b_r);
    m_r[0][1] <= mentry_t'(m01b_r);
    m_r[0][2] <= mentry_t'(m02b_r);
    m_r[1][0] <= mentry_t'(t10a_r) - mentry_t'(t10b_r);
    m_r[1][1] <= mentry_t'(t11a_r) + mentry_t'(t11b_r);
    m_r[1][2] <= mentry_t'(m12b_r);
    m_r[2][0] <= mentry_t'(t20a_r) + mentry_t'(t20b_r);
    m_r[2][1] <= mentry_t'(t21a_r) - mentry_t'(t21b_r);
    m_r[2][2] <= mentry_t'(m22b_r);
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        xform.m[r][c] = m_r[r][c];
      end
      xform.shift[r] = shift_r[r];
    end
  end

  assign in_tready = !queue_full && (settle_r == '0);
  assign push      = in_tvalid && in_tready;

  always_comb begin
    push_data.p[0] = in_tdata[COORD_BITS-1:0];
    push_data.p[1] = in_tdata[2*COORD_BITS-1:COORD_BITS];
    push_data.p[2] = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
    push_data.last = in_tlast;
  end

endmodule

[rtl/erp_back.sv]
// Back part: matrix multiply, translate, round toward zero and saturate.
module erp_back
  import erp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  xform_t                xform,
  input  logic                  q_valid,
  input  point_t                q_data,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [POINT_BITS-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int V_BITS = ACC_BITS - FRAC_BITS;
  localparam logic signed [V_BITS-1:0] V_MAX = V_BITS'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [V_BITS-1:0] V_MIN = -V_MAX - V_BITS'(1);

  logic a_v_r, b_v_r, c_v_r;
  logic a_rdy, b_rdy, c_rdy;
  logic a_last_r, b_last_r, c_last_r;
  logic signed [PROD_BITS-1:0] a_prod_r [3][3];
  logic signed [ACC_BITS-1:0]  b_acc_r [3];
  coord_t                      c_coord_r [3];
  logic                        c_clip_r;
  logic signed [PROD_BITS-1:0] prod_nxt [3][3];
  logic signed [ACC_BITS-1:0]  acc_nxt [3];
  coord_t                      coord_nxt [3];
  logic                        clip_nxt;

  assign c_rdy = !c_v_r || out_tready;
  assign b_rdy = !b_v_r || c_rdy;
  assign a_rdy = !a_v_r || b_rdy;
  assign q_pop = q_valid && a_rdy;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = q_data.p[c] * xform.m[r][c];
      end
    end
  end

  always_comb begin
    logic signed [ACC_BITS-1:0] sh;
    for (int r = 0; r < 3; r++) begin
      sh = $signed({{(ACC_BITS-COORD_BITS-FRAC_BITS){xform.shift[r][COORD_BITS-1]}},
                    xform.shift[r], {FRAC_BITS{1'b0}}});
      acc_nxt[r] = ACC_BITS'(a_prod_r[r][0]) + ACC_BITS'(a_prod_r[r][1])
                 + ACC_BITS'(a_prod_r[r][2]) + sh;
    end
  end

  always_comb begin
    logic signed [ACC_BITS-1:0] adj;
    logic signed [V_BITS-1:0]   v;
    clip_nxt = 1'b0;
    for (int r = 0; r < 3; r++) begin
      adj = b_acc_r[r] + (b_acc_r[r][ACC_BITS-1] ? ACC_BITS'((1 << FRAC_BITS) - 1)
                                                 : ACC_BITS'(0));
      v = adj[ACC_BITS-1:FRAC_BITS];
      if (v > V_MAX) begin
        coord_nxt[r] = V_MAX[COORD_BITS-1:0];
        clip_nxt     = 1'b1;
      end else if (v < V_MIN) begin
        coord_nxt[r] = V_MIN[COORD_BITS-1:0];
        clip_nxt     = 1'b1;
      end else begin
        coord_nxt[r] = v[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= q_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_prod_r <= prod_nxt;
      a_last_r <= q_data.last;
    end
    if (b_rdy && a_v_r) begin
      b_acc_r  <= acc_nxt;
      b_last_r <= a_last_r;
    end
    if (c_rdy && b_v_r) begin
      c_coord_r <= coord_nxt;
      c_clip_r  <= clip_nxt;
      c_last_r  <= b_last_r;
    end
  end

  assign out_tvalid = c_v_r;
  assign out_tdata  = {c_coord_r[2], c_coord_r[1], c_coord_r[0]};
  assign out_tuser  = c_clip_r;
  assign out_tlast  = c_last_r;

endmodule

[rtl/euler_rotate_translate_points_unit.sv]
// Top level: rotates each 3D point by three Euler angles and adds a translation.
// Takes one point per clock and returns one per clock at full rate while the
// output is not stalled and intake is not paused; an accepted point is written
// into the two-entry queue at the accepting edge, then passes the multiply,
// sum and round/saturate stages. After reset and after every register write,
// intake pauses while the matrix pipeline (sine lookup, two product stages and
// a sum stage) settles.
`include "assert_macros.svh"

module euler_rotate_translate_points_unit
  import erp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [POINT_BITS-1:0]    in_tdata,   // point_x, point_y, point_z
  input  logic                     in_tlast,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [POINT_BITS-1:0]    out_tdata,  // moved_x, moved_y, moved_z
  output logic                     out_tuser,  // clipped
  output logic                     out_tlast
);

  xform_t xform;
  point_t push_data, pop_data;
  logic   push, pop, pop_valid, queue_full;
  logic   cfg_write;
  logic   any_at_bound;

  erp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .queue_full  (queue_full),
    .push        (push),
    .push_data   (push_data),
    .xform       (xform)
  );

  erp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop)
  );

  erp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .xform      (xform),
    .q_valid    (pop_valid),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    any_at_bound = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((out_tdata[i*COORD_BITS +: COORD_BITS] == 24'h7FFFFF) ||
          (out_tdata[i*COORD_BITS +: COORD_BITS] == 24'h800000)) begin
        any_at_bound = 1'b1;
      end
    end
  end

  `ERP_ASSERT_NEXT(a_settle_after_write, cfg_write, !in_tready, "item accepted while settling")
  `ERP_ASSERT_ALWAYS(a_no_push_when_full, !(push && queue_full), "queue overflow")
  `ERP_ASSERT_ALWAYS(a_clip_at_bound, !(out_tvalid && out_tuser) || any_at_bound, "clip off bound")

endmodule
